// ===== rtl/rlkcl_pkg.sv =====
`timescale 1ns / 1ps

package rlkcl_pkg;

  localparam int SAMPLE_W = 12;
  localparam int DIGIT_W = 4;
  localparam int CODE_W = 16;
  localparam int HALF_W = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam int CODE_DIGITS_DEFAULT = 4;
  localparam int KEY_LEVELS = 10;
  localparam int TABLE_SIZE = 10;
  localparam int USED_LEVELS = (KEY_LEVELS < TABLE_SIZE) ? KEY_LEVELS : TABLE_SIZE;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HALF = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_FIRST = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_SECOND = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_TEMP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_TEMP_ENABLE = 3'd4;

  localparam logic [HALF_W-1:0] WINDOW_HALF_RESET = 8'd40;
  localparam logic [CODE_W-1:0] CODE_FIRST_RESET = 16'h1111;
  localparam logic [CODE_W-1:0] CODE_SECOND_RESET = 16'h2250;
  localparam logic [CODE_W-1:0] CODE_TEMP_RESET = 16'h0000;

  // key levels of the resistor ladder and the digit each one stands for
  localparam logic [SAMPLE_W-1:0] LEVEL_TABLE [TABLE_SIZE] = '{
    12'd2080, 12'd2520, 12'd3030, 12'd2280, 12'd2650,
    12'd3150, 12'd2400, 12'd2770, 12'd3210, 12'd2860
  };
  localparam logic [DIGIT_W-1:0] DIGIT_TABLE [TABLE_SIZE] = '{
    4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd0
  };

  typedef struct packed {
    logic [HALF_W-1:0] window_half;
    logic [CODE_W-1:0] code_first;
    logic [CODE_W-1:0] code_second;
    logic [CODE_W-1:0] code_temp;
    logic              code_temp_enable;
  } cfg_t;

  typedef struct packed {
    logic               hit;
    logic [DIGIT_W-1:0] digit;
    logic               done;
    logic               granted;
  } result_t;

endpackage

// ===== rtl/rlkcl_regs.sv =====
`timescale 1ns / 1ps

module rlkcl_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rlkcl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rlkcl_pkg::CFG_DATA_W-1:0]    cfg_data,
  output rlkcl_pkg::cfg_t                     cfg
);
  import rlkcl_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_half <= WINDOW_HALF_RESET;
      cfg.code_first <= CODE_FIRST_RESET;
      cfg.code_second <= CODE_SECOND_RESET;
      cfg.code_temp <= CODE_TEMP_RESET;
      cfg.code_temp_enable <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WINDOW_HALF: cfg.window_half <= cfg_data[HALF_W-1:0];
        REG_CODE_FIRST: cfg.code_first <= cfg_data[CODE_W-1:0];
        REG_CODE_SECOND: cfg.code_second <= cfg_data[CODE_W-1:0];
        REG_CODE_TEMP: cfg.code_temp <= cfg_data[CODE_W-1:0];
        REG_CODE_TEMP_ENABLE: cfg.code_temp_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/rlkcl_classify.sv =====
`timescale 1ns / 1ps

module rlkcl_classify (
  input  logic [rlkcl_pkg::SAMPLE_W-1:0] sample,
  input  logic [rlkcl_pkg::HALF_W-1:0]   window_half,
  output logic                           hit,
  output logic [rlkcl_pkg::DIGIT_W-1:0]  digit
);
  import rlkcl_pkg::*;

  logic [SAMPLE_W:0] s_ext;
  logic [SAMPLE_W:0] h_ext;
  logic [SAMPLE_W:0] s_plus_h;

  assign s_ext = {1'b0, sample};
  assign h_ext = {{(SAMPLE_W + 1 - HALF_W){1'b0}}, window_half};
  assign s_plus_h = s_ext + h_ext;

  // open window: level - h < s < level + h, first table entry wins
  always_comb begin
    hit = 1'b0;
    digit = '0;
    for (int i = USED_LEVELS - 1; i >= 0; i--) begin
      if ((s_plus_h > {1'b0, LEVEL_TABLE[i]}) &&
          (s_ext < ({1'b0, LEVEL_TABLE[i]} + h_ext))) begin
        hit = 1'b1;
        digit = DIGIT_TABLE[i];
      end
    end
  end

endmodule

// ===== rtl/rlkcl_entry.sv =====
`timescale 1ns / 1ps

module rlkcl_entry #(
  parameter int CODE_DIGITS = rlkcl_pkg::CODE_DIGITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  logic                          hit,
  input  logic [rlkcl_pkg::DIGIT_W-1:0] digit,
  input  rlkcl_pkg::cfg_t               cfg,
  output rlkcl_pkg::result_t            res
);
  import rlkcl_pkg::*;

  localparam int CNT_W = $clog2(CODE_DIGITS);

  logic [CNT_W-1:0]  cnt;
  logic [CODE_W-1:0] code;
  logic [CODE_W-1:0] code_next;
  logic              last;
  logic              match;

  // digits shift in at the bottom, so only the last four reach the compare
  assign code_next = (cnt == '0) ? {{(CODE_W - DIGIT_W){1'b0}}, digit}
                                 : {code[CODE_W-DIGIT_W-1:0], digit};
  assign last = (cnt == CNT_W'(CODE_DIGITS - 1));
  assign match = (code_next == cfg.code_first) || (code_next == cfg.code_second) ||
                 (cfg.code_temp_enable && (code_next == cfg.code_temp));

  assign res.hit = hit;
  assign res.digit = digit;
  assign res.done = hit && last;
  assign res.granted = hit && last && match;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (step && hit) begin
      cnt <= last ? '0 : cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (step && hit) begin
      code <= code_next;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(CODE_DIGITS - 1))
    else $error("digit count beyond code length");

  a_cnt_wrap: assert property (@(posedge clk) disable iff (rst)
    (step && hit && last) |=> (cnt == '0))
    else $error("digit count did not restart after a completed entry");

endmodule

// ===== rtl/resistor_ladder_keypad_code_lock.sv =====
// throughput: one sample per cycle unless result_stall holds a full result register;
//   classify, digit collect and code compare sit between the sample register and the
//   result register
// reset: rst is synchronous; it empties both registers, clears the digit count and
//   loads the config registers with their defaults
`timescale 1ns / 1ps

module resistor_ladder_keypad_code_lock #(
  parameter int CODE_DIGITS = rlkcl_pkg::CODE_DIGITS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             sample_valid,
  output logic                             sample_stall,
  input  logic [rlkcl_pkg::SAMPLE_W-1:0]   sample,
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic                             key_hit,
  output logic [rlkcl_pkg::DIGIT_W-1:0]    key_digit,
  output logic                             entry_done,
  output logic                             access_granted,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rlkcl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rlkcl_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rlkcl_pkg::*;

  cfg_t                cfg;
  result_t             res;
  logic                s1_valid;
  logic [SAMPLE_W-1:0] s1_sample;
  logic                adv;
  logic                step;
  logic                hit;
  logic [DIGIT_W-1:0]  digit;

  rlkcl_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rlkcl_classify u_classify (
    .sample      (s1_sample),
    .window_half (cfg.window_half),
    .hit         (hit),
    .digit       (digit)
  );

  rlkcl_entry #(
    .CODE_DIGITS (CODE_DIGITS)
  ) u_entry (
    .clk   (clk),
    .rst   (rst),
    .step  (step),
    .hit   (hit),
    .digit (digit),
    .cfg   (cfg),
    .res   (res)
  );

  // result register frees up when empty or when its transfer happens
  assign adv = !result_valid || !result_stall;
  assign step = adv && s1_valid;
  assign sample_stall = s1_valid && !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (adv) begin
        result_valid <= s1_valid;
      end
      if (!sample_stall) begin
        s1_valid <= sample_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sample_valid && !sample_stall) begin
      s1_sample <= sample;
    end
    if (step) begin
      key_hit <= res.hit;
      key_digit <= res.digit;
      entry_done <= res.done;
      access_granted <= res.granted;
    end
  end

  a_done_needs_hit: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (!entry_done || key_hit))
    else $error("entry completed without a key hit");

  a_grant_needs_done: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (!access_granted || entry_done))
    else $error("access granted without a completed entry");

  a_miss_digit_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !key_hit) |-> (key_digit == '0))
    else $error("digit set on a sample that missed every key");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    sample_stall |-> (s1_valid && result_valid && result_stall))
    else $error("input stalled while the pipeline had room");

endmodule
